// File: src/shl1acc_pkg.sv
`timescale 1ns / 1ps
package shl1acc_pkg;

  localparam int unsigned NCH = 3;
  localparam int unsigned NSUM = 12;
  localparam logic [16:0] Q16_ONE = 17'd65536;
  localparam logic [15:0] HALF_MAX = 16'h7bff;
  localparam logic [15:0] HALF_SIGN = 16'h8000;
  localparam logic [63:0] LIM_POS = 64'h0000_0000_7fff_ffff;
  localparam logic [63:0] LIM_NEG = 64'h0000_0000_8000_0000;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_ORDER   = 3'd1,
    ERR_PATCH   = 3'd2,
    ERR_WEIGHT  = 3'd3,
    ERR_PORDER  = 3'd4,
    ERR_NEG     = 3'd5,
    ERR_RANGE   = 3'd6,
    ERR_OVERRUN = 3'd7
  } err_e;

  typedef enum logic [0:0] {
    REQ_SAMPLE = 1'b0,
    REQ_CLOSE  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    CFG_PROBE_COUNT = 2'd0,
    CFG_PATCH_COUNT = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIR,
    ST_ACC,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_NORM,
    ST_EMIT
  } core_state_e;

  typedef struct packed {
    logic              is_close;
    logic [19:0]       probe;
    logic [19:0]       patch;
    logic [16:0]       weight;
    logic              w_over;
    logic              skip;
    logic              rad_neg;
    logic [2:0][30:0]  rad;
    logic [2:0][17:0]  dir;
  } item_t;

endpackage

// File: src/shl1acc_front.sv
`timescale 1ns / 1ps
module shl1acc_front
  import shl1acc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [19:0] probe_index_i,
  input  logic [19:0] patch_index_i,
  input  logic [16:0] weight_i,
  input  logic        occluded_i,
  input  logic [31:0] radiance_r_i,
  input  logic [31:0] radiance_g_i,
  input  logic [31:0] radiance_b_i,
  input  logic [17:0] dir_x_i,
  input  logic [17:0] dir_y_i,
  input  logic [17:0] dir_z_i,
  output logic        q_valid_o,
  input  logic        q_ready_i,
  output item_t       q_item_o
);

  item_t       mem_q [2];
  item_t       cls;
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  always_comb begin
    cls.is_close = (req_type_i == REQ_CLOSE);
    cls.probe    = probe_index_i;
    cls.patch    = patch_index_i;
    cls.weight   = weight_i;
    cls.w_over   = weight_i > Q16_ONE;
    cls.skip     = occluded_i | (weight_i == 17'd0);
    cls.rad_neg  = radiance_r_i[31] | radiance_g_i[31] | radiance_b_i[31];
    cls.rad[0]   = radiance_r_i[30:0];
    cls.rad[1]   = radiance_g_i[30:0];
    cls.rad[2]   = radiance_b_i[30:0];
    cls.dir[0]   = dir_x_i;
    cls.dir[1]   = dir_y_i;
    cls.dir[2]   = dir_z_i;
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i & in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o & q_ready_i;
  assign q_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: src/shl1acc_div.sv
`timescale 1ns / 1ps
module shl1acc_div #(
  parameter int unsigned DW = 48
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [63:0]   dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [63:0]   quotient_o
);

  logic [DW:0]   rem_q, rem_sh, rem_sub;
  logic [63:0]   quo_q;
  logic [DW-1:0] dvs_q;
  logic [5:0]    cnt_q;
  logic          busy_q, done_q, take;

  assign rem_sh     = {rem_q[DW-1:0], quo_q[63]};
  assign rem_sub    = rem_sh - {1'b0, dvs_q};
  assign take       = rem_sh >= {1'b0, dvs_q};
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= take ? rem_sub : rem_sh;
      quo_q <= {quo_q[62:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// File: src/shl1acc_core.sv
`timescale 1ns / 1ps
module shl1acc_core
  import shl1acc_pkg::*;
#(
  parameter int unsigned PROBE_BITS      = 20,
  parameter int unsigned PATCH_BITS      = 20,
  parameter int unsigned WEIGHT_SUM_BITS = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [20:0] cfg_data_i,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  item_t       q_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [19:0] out_probe_o,
  output logic [1:0]  coef_index_o,
  output logic [15:0] half_r_o,
  output logic [15:0] half_g_o,
  output logic [15:0] half_b_o,
  output logic        probe_valid_o,
  output logic [2:0]  error_code_o,
  output logic        last_o
);

  localparam int unsigned WS = WEIGHT_SUM_BITS;

  core_state_e         st_q, st_d;
  logic [20:0]         pcnt_q, ptcnt_q;
  logic [20:0]         cur_q, cur_d, cur_m;
  logic [63:0]         sums_q [NSUM];
  logic [63:0]         sums_d [NSUM];
  logic [WS-1:0]       wt_q, wt_d;
  logic [PATCH_BITS-1:0] prior_q, prior_d, patch_m;
  logic [31:0]         patch_ext;
  logic                has_prior_q, has_prior_d;
  err_e                err_q, err_d;
  item_t               item_q, item_d;
  logic [2:0][47:0]    p_q, p_d;
  logic [2:0][63:0]    mag_q, mag_d;
  logic                neg_q, neg_d;
  logic [1:0]          k_q, k_d;
  logic [3:0]          idx_q, idx_d;
  logic [15:0]         halves_q [NSUM];
  logic [15:0]         halves_d [NSUM];
  logic                valid_q, valid_d;
  logic [19:0]         oprobe_q, oprobe_d;
  logic [31:0]         cv_q, cv_d, corig_q, corig_d;
  logic [4:0]          ctop_q, ctop_d;
  logic                cneg_q, cneg_d, sneg_q, sneg_d;
  logic                div_start, div_done;
  logic [63:0]         div_quo, div_dvd;
  logic [17:0]         ad;
  logic [49:0]         hi_prod [NCH];
  logic [33:0]         lo_prod [NCH];
  logic [4:0]          he;
  logic [10:0]         hm;
  logic [15:0]         hval;
  logic                clear, advance, zero_halves;

  always_comb begin
    for (int b = 0; b < 21; b++) begin
      cur_m[b] = (b < PROBE_BITS) ? cur_q[b] : 1'b0;
    end
  end
  assign patch_ext = {12'd0, q_item_i.patch};
  assign patch_m   = patch_ext[PATCH_BITS-1:0];
  assign div_dvd   = sums_q[0][63] ? (64'd0 - sums_q[0]) : sums_q[0];

  shl1acc_div #(.DW(WS)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (wt_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    ad = item_q.dir[k_q][17] ? (~item_q.dir[k_q] + 18'd1) : item_q.dir[k_q];
    for (int c = 0; c < NCH; c++) begin
      hi_prod[c] = p_q[c][47:16] * ad;
      lo_prod[c] = p_q[c][15:0] * ad;
    end
    he = ctop_q - 5'd1;
    hm = {1'b0, cv_q[30:21]} + {10'd0, cv_q[20]};
    if (cv_q == 32'd0) begin
      hval = 16'd0;
    end else if (ctop_q < 5'd2) begin
      hval = {corig_q[7:0], 8'd0};
    end else if (hm[10] && he == 5'd30) begin
      hval = HALF_MAX;
    end else if (hm[10]) begin
      hval = {1'b0, he + 5'd1, 10'd0};
    end else begin
      hval = {1'b0, he, hm[9:0]};
    end
    if (cneg_q) hval = hval | HALF_SIGN;
  end

  always_comb begin
    st_d        = st_q;
    cur_d       = cur_q;
    sums_d      = sums_q;
    wt_d        = wt_q;
    prior_d     = prior_q;
    has_prior_d = has_prior_q;
    err_d       = err_q;
    item_d      = item_q;
    p_d         = p_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    k_d         = k_q;
    idx_d       = idx_q;
    halves_d    = halves_q;
    valid_d     = valid_q;
    oprobe_d    = oprobe_q;
    cv_d        = cv_q;
    corig_d     = corig_q;
    ctop_d      = ctop_q;
    cneg_d      = cneg_q;
    sneg_d      = sneg_q;
    q_ready_o   = 1'b0;
    div_start   = 1'b0;
    clear       = 1'b0;
    advance     = 1'b0;
    zero_halves = 1'b0;

    case (st_q)
      ST_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          item_d = q_item_i;
          if (q_item_i.is_close) begin
            oprobe_d = cur_m[19:0];
            valid_d  = 1'b0;
            k_d      = 2'd0;
            if (cur_q >= pcnt_q) begin
              if (err_q == ERR_NONE) err_d = ERR_OVERRUN;
              zero_halves = 1'b1;
              clear       = 1'b1;
              st_d        = ST_EMIT;
            end else if (err_q == ERR_NONE && wt_q != '0) begin
              idx_d = 4'd0;
              st_d  = ST_DIV_START;
            end else begin
              zero_halves = 1'b1;
              clear       = 1'b1;
              advance     = 1'b1;
              st_d        = ST_EMIT;
            end
          end else if (err_q == ERR_NONE) begin
            if (cur_q >= pcnt_q) begin
              err_d = ERR_OVERRUN;
            end else if (cur_m != {1'b0, q_item_i.probe}) begin
              err_d = ERR_ORDER;
            end else if ({1'b0, q_item_i.patch} >= ptcnt_q) begin
              err_d = ERR_PATCH;
            end else if (q_item_i.w_over) begin
              err_d = ERR_WEIGHT;
            end else if (has_prior_q && prior_q >= patch_m) begin
              err_d = ERR_PORDER;
            end else begin
              prior_d     = patch_m;
              has_prior_d = 1'b1;
              if (!q_item_i.skip) begin
                if (q_item_i.rad_neg) begin
                  err_d = ERR_NEG;
                end else begin
                  st_d = ST_MUL;
                end
              end
            end
          end
        end
      end
      ST_MUL: begin
        for (int c = 0; c < NCH; c++) begin
          p_d[c] = item_q.rad[c] * item_q.weight;
        end
        k_d  = 2'd0;
        st_d = ST_DIR;
      end
      ST_DIR: begin
        neg_d = item_q.dir[k_q][17];
        for (int c = 0; c < NCH; c++) begin
          mag_d[c] = 64'(hi_prod[c]) + 64'(lo_prod[c][33:16]);
          if (k_q == 2'd0) sums_d[c] = sums_q[c] + 64'(p_q[c]);
        end
        st_d = ST_ACC;
      end
      ST_ACC: begin
        for (int j = 1; j < 4; j++) begin
          for (int c = 0; c < NCH; c++) begin
            if (k_q == 2'(j - 1)) begin
              sums_d[j * 3 + c] = neg_q ? (sums_q[j * 3 + c] - mag_q[c])
                                        : (sums_q[j * 3 + c] + mag_q[c]);
            end
          end
        end
        if (k_q == 2'd2) begin
          wt_d = wt_q + WS'(item_q.weight);
          st_d = ST_IDLE;
        end else begin
          k_d  = k_q + 2'd1;
          st_d = ST_DIR;
        end
      end
      ST_DIV_START: begin
        div_start = 1'b1;
        sneg_d    = sums_q[0][63];
        st_d      = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (div_quo > (sneg_q ? LIM_NEG : LIM_POS)) begin
            err_d       = ERR_RANGE;
            zero_halves = 1'b1;
            clear       = 1'b1;
            advance     = 1'b1;
            k_d         = 2'd0;
            st_d        = ST_EMIT;
          end else begin
            cv_d    = div_quo[31:0];
            corig_d = div_quo[31:0];
            ctop_d  = 5'd31;
            cneg_d  = sneg_q && (div_quo != 64'd0);
            st_d    = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        if (cv_q != 32'd0 && !cv_q[31]) begin
          cv_d   = {cv_q[30:0], 1'b0};
          ctop_d = ctop_q - 5'd1;
        end else begin
          for (int i = 0; i < NSUM - 1; i++) begin
            halves_d[i] = halves_q[i + 1];
            sums_d[i]   = sums_q[i + 1];
          end
          halves_d[NSUM-1] = hval;
          sums_d[NSUM-1]   = 64'd0;
          if (idx_q == 4'(NSUM - 1)) begin
            valid_d = 1'b1;
            clear   = 1'b1;
            advance = 1'b1;
            k_d     = 2'd0;
            st_d    = ST_EMIT;
          end else begin
            idx_d = idx_q + 4'd1;
            st_d  = ST_DIV_START;
          end
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          for (int i = 0; i < NSUM - 3; i++) begin
            halves_d[i] = halves_q[i + 3];
          end
          if (k_q == 2'd3) begin
            st_d = ST_IDLE;
          end else begin
            k_d = k_q + 2'd1;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase

    if (zero_halves) begin
      for (int i = 0; i < NSUM; i++) halves_d[i] = 16'd0;
    end
    if (clear) begin
      for (int i = 0; i < NSUM; i++) sums_d[i] = 64'd0;
      wt_d        = '0;
      prior_d     = '0;
      has_prior_d = 1'b0;
    end
    if (advance) cur_d = cur_q + 21'd1;
  end

  assign out_valid_o   = (st_q == ST_EMIT);
  assign out_probe_o   = oprobe_q;
  assign coef_index_o  = k_q;
  assign half_r_o      = halves_q[0];
  assign half_g_o      = halves_q[1];
  assign half_b_o      = halves_q[2];
  assign probe_valid_o = valid_q;
  assign error_code_o  = err_q;
  assign last_o        = (k_q == 2'd3);

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    p_q      <= p_d;
    mag_q    <= mag_d;
    neg_q    <= neg_d;
    idx_q    <= idx_d;
    halves_q <= halves_d;
    oprobe_q <= oprobe_d;
    cv_q     <= cv_d;
    corig_q  <= corig_d;
    ctop_q   <= ctop_d;
    cneg_q   <= cneg_d;
    sneg_q   <= sneg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      pcnt_q      <= 21'd8;
      ptcnt_q     <= 21'd0;
      cur_q       <= 21'd0;
      wt_q        <= '0;
      prior_q     <= '0;
      has_prior_q <= 1'b0;
      err_q       <= ERR_NONE;
      k_q         <= 2'd0;
      valid_q     <= 1'b0;
      for (int i = 0; i < NSUM; i++) sums_q[i] <= 64'd0;
    end else begin
      st_q        <= st_d;
      cur_q       <= cur_d;
      wt_q        <= wt_d;
      prior_q     <= prior_d;
      has_prior_q <= has_prior_d;
      err_q       <= err_d;
      k_q         <= k_d;
      valid_q     <= valid_d;
      sums_q      <= sums_d;
      if (cfg_valid_i && cfg_index_i == CFG_PROBE_COUNT) pcnt_q  <= cfg_data_i;
      if (cfg_valid_i && cfg_index_i == CFG_PATCH_COUNT) ptcnt_q <= cfg_data_i;
    end
  end

endmodule

// File: src/sh_l1_probe_accumulator.sv
`timescale 1ns / 1ps
// SH L1 probe accumulator.
// Input stream s_axis: one word per sample or close request; tuser carries
// req_type (0 sample, 1 close). Words enter a two-entry queue, so the input
// keeps accepting while the accumulator works or the output stalls.
// Output stream m_axis: four words per close (coefficient 0..3), tlast on
// the fourth. Sample requests produce no output.
// Configuration: cfg_valid_i/cfg_ready_o write channel, index 0 probe_count,
// index 1 patch_count; ready is always high, writes are registered.
// Processing: a sample that accumulates passes through a product step,
// then a multiply and an accumulate step for each of the three
// directions; a skipped or rejected sample is handled in the idle state.
// A valid close runs twelve serial divisions on one radix-2 divider, each
// followed by a normalize shift of its coefficient, then four output
// words. The back end takes no new word before it is done with the last.
// An invalid close emits zero halves straight from the idle state.
// Reset clears all sums, counters and the sticky error and restores
// probe_count 8, patch_count 0. When the receiver stalls, the output word
// holds and the back end waits; the queue fills and then drops tready.
module sh_l1_probe_accumulator
  import shl1acc_pkg::*;
#(
  parameter int unsigned PROBE_BITS      = 20,
  parameter int unsigned PATCH_BITS      = 20,
  parameter int unsigned WEIGHT_SUM_BITS = 48
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [20:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // probe_index[19:0] patch_index[39:20] weight[56:40] occluded[57]
  // radiance_r[89:58] radiance_g[121:90] radiance_b[153:122]
  // dir_x[171:154] dir_y[189:172] dir_z[207:190]
  input  logic [207:0] s_axis_tdata,
  // req_type[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_probe[19:0] coef_index[21:20] half_r[37:22] half_g[53:38]
  // half_b[69:54] probe_valid[70] error_code[73:71] zero[79:74]
  output logic [79:0]  m_axis_tdata,
  output logic         m_axis_tlast
);

  logic        q_valid, q_ready;
  item_t       q_item;
  logic [19:0] out_probe;
  logic [1:0]  coef_index;
  logic [15:0] half_r, half_g, half_b;
  logic        probe_valid;
  logic [2:0]  error_code;

  assign cfg_ready_o = 1'b1;

  shl1acc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .req_type_i    (s_axis_tuser),
    .probe_index_i (s_axis_tdata[19:0]),
    .patch_index_i (s_axis_tdata[39:20]),
    .weight_i      (s_axis_tdata[56:40]),
    .occluded_i    (s_axis_tdata[57]),
    .radiance_r_i  (s_axis_tdata[89:58]),
    .radiance_g_i  (s_axis_tdata[121:90]),
    .radiance_b_i  (s_axis_tdata[153:122]),
    .dir_x_i       (s_axis_tdata[171:154]),
    .dir_y_i       (s_axis_tdata[189:172]),
    .dir_z_i       (s_axis_tdata[207:190]),
    .q_valid_o     (q_valid),
    .q_ready_i     (q_ready),
    .q_item_o      (q_item)
  );

  shl1acc_core #(
    .PROBE_BITS      (PROBE_BITS),
    .PATCH_BITS      (PATCH_BITS),
    .WEIGHT_SUM_BITS (WEIGHT_SUM_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .q_valid_i     (q_valid),
    .q_ready_o     (q_ready),
    .q_item_i      (q_item),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_probe_o   (out_probe),
    .coef_index_o  (coef_index),
    .half_r_o      (half_r),
    .half_g_o      (half_g),
    .half_b_o      (half_b),
    .probe_valid_o (probe_valid),
    .error_code_o  (error_code),
    .last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, error_code, probe_valid, half_b, half_g, half_r,
                         coef_index, out_probe};

endmodule
